// ===== hdl/wsdm_pkg.sv =====
// Package: shared types, constants and helpers for the window std-dev map.
`timescale 1ns / 1ps
`default_nettype none
package wsdm_pkg;
    localparam int MAX_IMAGE_WIDTH   = 1024;
    localparam int MAX_IMAGE_HEIGHT  = 1024;
    localparam int MAX_WINDOW_WIDTH  = 32;
    localparam int MAX_WINDOW_HEIGHT = 32;

    localparam int XW    = $clog2(MAX_IMAGE_WIDTH);
    localparam int YW    = $clog2(MAX_IMAGE_HEIGHT);
    localparam int SLW   = $clog2(MAX_WINDOW_HEIGHT);
    localparam int DIMW  = 11;
    localparam int WINW  = 6;
    localparam int CSW   = 13;
    localparam int CSQW  = 21;
    localparam int WSW   = 18;
    localparam int WSQW  = 26;
    localparam int NW    = 11;
    localparam int AW    = NW + WSQW;
    localparam int BW    = 2 * WSW;
    localparam int DW    = 20;
    localparam int NUMW  = AW + 16;
    localparam int SQVW  = NUMW + 1;
    localparam int ROOTW = SQVW / 2;
    localparam int SREMW = ROOTW + 2;
    localparam int CNTW  = 6;
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd2;
    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd3;

    typedef enum logic [1:0] {FR_IDLE, FR_READ, FR_FETCH, FR_UPDATE} front_state_t;
    typedef enum logic [2:0] {BK_IDLE, BK_MULT, BK_DIFF, BK_DIV, BK_SQRT, BK_HOLD} back_state_t;

    typedef struct packed {
        logic [XW-1:0]   win_x;
        logic [YW-1:0]   win_y;
        logic [WSW-1:0]  sum;
        logic [WSQW-1:0] sq_sum;
    } win_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

    function automatic logic [DIMW-1:0] clamp_dim(input logic [DIMW-1:0] v,
                                                  input logic [DIMW-1:0] hi);
        logic [DIMW-1:0] r;
        r = v;
        if (v < DIMW'(2))
            r = DIMW'(2);
        else if (v > hi)
            r = hi;
        return r;
    endfunction

    function automatic logic [WINW-1:0] clamp_win(input logic [WINW-1:0] v,
                                                  input logic [WINW-1:0] hi);
        logic [WINW-1:0] r;
        r = v;
        if (v < WINW'(2))
            r = WINW'(2);
        else if (v > hi)
            r = hi;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/wsdm_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wsdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== hdl/wsdm_front.sv =====
// Front end: pixel intake, line store, column and window running sums.
`timescale 1ns / 1ps
`default_nettype none
module wsdm_front import wsdm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tuser,
    input  wire logic [DIMW-1:0]   img_w,
    input  wire logic [DIMW-1:0]   img_h,
    input  wire logic [WINW-1:0]   win_w,
    input  wire logic [WINW-1:0]   win_h,
    input  wire logic              q_full,
    output logic                   q_push,
    output win_entry_t             q_entry
);
    front_state_t state_reg, state_next;
    logic [XW-1:0]   col_pos_reg, col_pos_next;
    logic [YW-1:0]   row_pos_reg, row_pos_next;
    logic [SLW-1:0]  slot_pos_reg, slot_pos_next;
    logic [WSW-1:0]  ws_reg, ws_next;
    logic [WSQW-1:0] wsq_reg, wsq_next;

    logic [XW-1:0]   x_reg;
    logic [YW-1:0]   y_reg;
    logic [SLW-1:0]  slot_reg;
    logic [7:0]      pix_reg;
    logic [7:0]      old_reg;
    logic [CSW-1:0]  cs_old_reg;
    logic [CSQW-1:0] css_old_reg;

    logic [XW-1:0]   x0;
    logic [YW:0]     y0;
    logic [SLW:0]    sl0;
    logic            accept;

    logic [7:0]           rs_rdata;
    logic [CSQW+CSW-1:0]  cm_rdata, cm_wdata;
    logic [XW-1:0]        cm_addr;
    logic                 cm_we, rs_we;

    logic [15:0]     pp, oo;
    logic [CSW-1:0]  cs_new;
    logic [CSQW-1:0] css_new;
    logic [XW:0]     x1;
    logic [YW:0]     y1;
    logic [SLW:0]    sl1;
    logic            emit;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == FR_IDLE) && !q_full;

    always_comb
    begin
        x0  = s_tuser ? '0 : col_pos_reg;
        y0  = s_tuser ? '0 : {1'b0, row_pos_reg};
        sl0 = s_tuser ? '0 : {1'b0, slot_pos_reg};
        if ({1'b0, x0} >= img_w)
        begin
            x0  = '0;
            y0  = y0 + 1'b1;
            sl0 = (sl0 + 1'b1 >= {1'b0, win_h}) ? '0 : sl0 + 1'b1;
        end
        if (y0 >= {1'b0, img_h})
        begin
            y0  = '0;
            sl0 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= x0;
            y_reg    <= y0[YW-1:0];
            slot_reg <= sl0[SLW-1:0];
            pix_reg  <= s_tdata;
        end
        if (state_reg == FR_FETCH)
        begin
            old_reg     <= rs_rdata;
            cs_old_reg  <= cm_rdata[CSW-1:0];
            css_old_reg <= cm_rdata[CSQW+CSW-1:CSW];
        end
    end

    assign rs_we   = (state_reg == FR_UPDATE);
    assign cm_we   = (state_reg == FR_UPDATE);
    assign cm_addr = (state_reg == FR_FETCH) ? x_reg - XW'(win_w) : x_reg;
    assign cm_wdata = {css_new, cs_new};

    wsdm_ram #(.WIDTH(8), .DEPTH(MAX_WINDOW_HEIGHT * MAX_IMAGE_WIDTH)) u_row_store (
        .clk   (clk),
        .we    (rs_we),
        .addr  ({slot_reg, x_reg}),
        .wdata (pix_reg),
        .rdata (rs_rdata)
    );

    wsdm_ram #(.WIDTH(CSQW + CSW), .DEPTH(MAX_IMAGE_WIDTH)) u_col_store (
        .clk   (clk),
        .we    (cm_we),
        .addr  (cm_addr),
        .wdata (cm_wdata),
        .rdata (cm_rdata)
    );

    always_comb
    begin
        pp = pix_reg * pix_reg;
        oo = old_reg * old_reg;
        if (y_reg == '0)
        begin
            cs_new  = CSW'(pix_reg);
            css_new = CSQW'(pp);
        end
        else
        begin
            cs_new  = cs_old_reg + CSW'(pix_reg);
            css_new = css_old_reg + CSQW'(pp);
            if ({1'b0, y_reg} >= YW'(win_h))
            begin
                cs_new  = cs_new - CSW'(old_reg);
                css_new = css_new - CSQW'(oo);
            end
        end
        if (x_reg == '0)
        begin
            ws_next  = WSW'(cs_new);
            wsq_next = WSQW'(css_new);
        end
        else
        begin
            ws_next  = ws_reg + WSW'(cs_new);
            wsq_next = wsq_reg + WSQW'(css_new);
            if ({1'b0, x_reg} >= (XW+1)'(win_w))
            begin
                ws_next  = ws_next - WSW'(cm_rdata[CSW-1:0]);
                wsq_next = wsq_next - WSQW'(cm_rdata[CSQW+CSW-1:CSW]);
            end
        end
        x1  = {1'b0, x_reg} + 1'b1;
        y1  = {1'b0, y_reg} + 1'b1;
        emit = (x1 >= (XW+1)'(win_w)) && (y1 >= (YW+1)'(win_h))
            && (x1 < img_w) && (y1 < img_h);
        q_entry.win_x  = x1[XW-1:0] - XW'(win_w);
        q_entry.win_y  = y1[YW-1:0] - YW'(win_h);
        q_entry.sum    = ws_next;
        q_entry.sq_sum = wsq_next;
        q_push = (state_reg == FR_UPDATE) && emit;

        sl1 = {1'b0, slot_reg};
        if (x1 >= img_w)
        begin
            x1  = '0;
            sl1 = (sl1 + 1'b1 >= {1'b0, win_h}) ? '0 : sl1 + 1'b1;
            if (y1 >= {1'b0, img_h})
            begin
                y1  = '0;
                sl1 = '0;
            end
        end
        else
            y1 = {1'b0, y_reg};
        col_pos_next  = x1[XW-1:0];
        row_pos_next  = y1[YW-1:0];
        slot_pos_next = sl1[SLW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:   if (accept) state_next = FR_READ;
            FR_READ:   state_next = FR_FETCH;
            FR_FETCH:  state_next = FR_UPDATE;
            FR_UPDATE: state_next = FR_IDLE;
            default:   state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FR_IDLE;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            slot_pos_reg <= '0;
            ws_reg       <= '0;
            wsq_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FR_UPDATE)
            begin
                col_pos_reg  <= col_pos_next;
                row_pos_reg  <= row_pos_next;
                slot_pos_reg <= slot_pos_next;
                ws_reg       <= ws_next;
                wsq_reg      <= wsq_next;
            end
        end
    end

    a_push_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> state_reg == FR_UPDATE) else $error("push outside update");
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == FR_READ) else $error("accept did not start read");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !q_full) else $error("accepted with full queue");
endmodule
`default_nettype wire

// ===== hdl/wsdm_queue.sv =====
// Small FIFO of window sums between front and back.
`timescale 1ns / 1ps
`default_nettype none
module wsdm_queue import wsdm_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  win_entry_t wr_entry,
    input  wire logic  pop,
    output win_entry_t rd_entry,
    output queue_ctl_t ctl
);
    win_entry_t      slots [QDEPTH];
    logic [QPW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]    count_reg;

    assign rd_entry  = slots[rd_ptr_reg];
    assign ctl.push  = push;
    assign ctl.pop   = pop;
    assign ctl.full  = (count_reg == (QPW+1)'(QDEPTH));
    assign ctl.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QPW+1)'(push) - (QPW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/wsdm_back.sv =====
// Back end: variance, long division and square root, output register.
`timescale 1ns / 1ps
`default_nettype none
module wsdm_back import wsdm_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [WINW-1:0] win_w,
    input  wire logic [WINW-1:0] win_h,
    input  win_entry_t           q_entry,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [39:0]          m_tdata
);
    back_state_t state_reg, state_next;
    logic [XW-1:0]    wx_reg;
    logic [YW-1:0]    wy_reg;
    logic [WSW-1:0]   s_reg;
    logic [WSQW-1:0]  sq_reg;
    logic [NW-1:0]    n_reg;
    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [DW-1:0]    d_reg;
    logic [NUMW-1:0]  num_reg;
    logic [DW-1:0]    rem_reg;
    logic [SQVW-1:0]  val_reg;
    logic [SREMW-1:0] srem_reg;
    logic [ROOTW-1:0] root_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             out_valid_reg;
    logic [XW-1:0]    out_x_reg;
    logic [YW-1:0]    out_y_reg;
    logic [15:0]      out_sd_reg;

    logic [DW:0]      dtrial;
    logic [SREMW-1:0] srem_sh, strial;
    logic [11:0]      nprod;
    logic             out_free;

    assign q_pop    = (state_reg == BK_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_sd_reg, out_y_reg, out_x_reg};
    assign nprod    = win_w * win_h;
    assign dtrial   = {rem_reg, num_reg[NUMW-1]};
    assign srem_sh  = {srem_reg[SREMW-3:0], val_reg[SQVW-1:SQVW-2]};
    assign strial   = {root_reg, 2'b01};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_MULT;
            BK_MULT: state_next = BK_DIFF;
            BK_DIFF: state_next = BK_DIV;
            BK_DIV:  if (cnt_reg == CNTW'(NUMW - 1)) state_next = BK_SQRT;
            BK_SQRT: if (cnt_reg == CNTW'(ROOTW - 1)) state_next = BK_HOLD;
            BK_HOLD: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                wx_reg <= q_entry.win_x;
                wy_reg <= q_entry.win_y;
                s_reg  <= q_entry.sum;
                sq_reg <= q_entry.sq_sum;
                n_reg  <= nprod[NW-1:0];
            end
            BK_MULT:
            begin
                a_reg <= n_reg * sq_reg;
                b_reg <= s_reg * s_reg;
                d_reg <= DW'(n_reg) * DW'(n_reg - 1'b1);
            end
            BK_DIFF:
            begin
                num_reg <= (a_reg > AW'(b_reg)) ? {a_reg - AW'(b_reg), 16'd0} : '0;
                rem_reg <= '0;
            end
            BK_DIV:
            begin
                if (dtrial >= {1'b0, d_reg})
                begin
                    rem_reg <= DW'(dtrial - {1'b0, d_reg});
                    num_reg <= {num_reg[NUMW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= dtrial[DW-1:0];
                    num_reg <= {num_reg[NUMW-2:0], 1'b0};
                end
                if (cnt_reg == CNTW'(NUMW - 1))
                begin
                    val_reg  <= {1'b0, num_reg[NUMW-2:0], (dtrial >= {1'b0, d_reg})};
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            BK_SQRT:
            begin
                val_reg <= {val_reg[SQVW-3:0], 2'b00};
                if (srem_sh >= strial)
                begin
                    srem_reg <= srem_sh - strial;
                    root_reg <= {root_reg[ROOTW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[ROOTW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_sd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == BK_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_x_reg     <= wx_reg;
                out_y_reg     <= wy_reg;
                out_sd_reg    <= (root_reg[ROOTW-1:16] != '0) ? 16'hFFFF : root_reg[15:0];
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> cnt_reg < CNTW'(NUMW)) else $error("divide overrun");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BK_MULT) else $error("pop without start");
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_HOLD && out_free) |=> out_valid_reg) else $error("result lost");
endmodule
`default_nettype wire

// ===== hdl/window_std_dev_map.sv =====
// Top level: sliding-window standard deviation map.
// Front accepts a pixel only when idle and the queue is not full, then runs read, fetch and
// update (three RAM accesses on single-port stores). Back handles one window result at a
// time (53-step divider, 27-step root, control states); a 4-entry queue decouples them.
// Reset clears position, window sums, queue and output; line and column stores keep
// their contents. Configuration returns to 640 x 480 with a 24 x 24 window.
`timescale 1ns / 1ps
`default_nettype none
module window_std_dev_map import wsdm_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // pixel_value
    input  wire logic        s_tuser,    // frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // win_x, win_y, std_dev, zero pad
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    logic [DIMW-1:0] img_w_reg, img_h_reg;
    logic [WINW-1:0] win_w_reg, win_h_reg;
    logic [DIMW-1:0] img_w, img_h;
    logic [WINW-1:0] win_w, win_h;
    logic            q_push;
    win_entry_t      q_wr, q_rd;
    queue_ctl_t      q_ctl;
    logic            q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= DIMW'(640);
            img_h_reg <= DIMW'(480);
            win_w_reg <= WINW'(24);
            win_h_reg <= WINW'(24);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   img_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT:  img_h_reg <= cfg_data;
                REG_WINDOW_WIDTH:  win_w_reg <= cfg_data[WINW-1:0];
                REG_WINDOW_HEIGHT: win_h_reg <= cfg_data[WINW-1:0];
                default: ;
            endcase
        end
    end

    assign img_w = clamp_dim(img_w_reg, DIMW'(MAX_IMAGE_WIDTH));
    assign img_h = clamp_dim(img_h_reg, DIMW'(MAX_IMAGE_HEIGHT));
    assign win_w = clamp_win(win_w_reg, WINW'(MAX_WINDOW_WIDTH));
    assign win_h = clamp_win(win_h_reg, WINW'(MAX_WINDOW_HEIGHT));

    wsdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .img_w    (img_w),
        .img_h    (img_h),
        .win_w    (win_w),
        .win_h    (win_h),
        .q_full   (q_ctl.full),
        .q_push   (q_push),
        .q_entry  (q_wr)
    );

    wsdm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr),
        .pop      (q_pop),
        .rd_entry (q_rd),
        .ctl      (q_ctl)
    );

    wsdm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .win_w    (win_w),
        .win_h    (win_h),
        .q_entry  (q_rd),
        .q_empty  (q_ctl.empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire

// ===== dv/window_std_dev_map_checker.sv =====
// Checker: predicts window std-dev results from observed pixels and compares outputs.
`timescale 1ns / 1ps
module window_std_dev_map_checker import wsdm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [15:0] std_dev;
        logic [9:0]  win_y;
        logic [9:0]  win_x;
    } stat_t;

    stat_t stat_q[$];

    logic [10:0] img_w_reg, img_h_reg;
    logic [5:0]  win_w_reg, win_h_reg;
    logic [7:0]  line_mem [MAX_WINDOW_HEIGHT*MAX_IMAGE_WIDTH];
    int unsigned col_sum [MAX_IMAGE_WIDTH];
    int unsigned col_sq  [MAX_IMAGE_WIDTH];
    int unsigned win_sum, win_sq, cur_x, cur_y;

    function automatic int unsigned clampv(int unsigned v, int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic take_pixel(input int unsigned p, input bit fs);
        int unsigned w, h, ww, wh, x, y, idx, old, cs, css, s, sq, tx, ty;
        longint unsigned n, a, b, q, r;
        stat_t e;
        w  = clampv(32'(img_w_reg), MAX_IMAGE_WIDTH);
        h  = clampv(32'(img_h_reg), MAX_IMAGE_HEIGHT);
        ww = clampv(32'(win_w_reg), MAX_WINDOW_WIDTH);
        wh = clampv(32'(win_h_reg), MAX_WINDOW_HEIGHT);
        x = cur_x;
        y = cur_y;
        if (fs)
        begin
            x = 0;
            y = 0;
        end
        if (x >= w)
        begin
            x = 0;
            y++;
        end
        if (y >= h)
            y = 0;
        idx = (y % wh) * MAX_IMAGE_WIDTH + x;
        old = 32'(line_mem[idx]);
        line_mem[idx] = p[7:0];
        if (y == 0)
        begin
            col_sum[x] = p;
            col_sq[x] = p * p;
        end
        else
        begin
            cs = col_sum[x] + p;
            css = col_sq[x] + p * p;
            if (y >= wh)
            begin
                cs -= old;
                css -= old * old;
            end
            col_sum[x] = cs & 32'h1FFF;
            col_sq[x] = css & 32'h1FFFFF;
        end
        if (x == 0)
        begin
            win_sum = col_sum[0];
            win_sq = col_sq[0];
        end
        else
        begin
            s = win_sum + col_sum[x];
            sq = win_sq + col_sq[x];
            if (x >= ww)
            begin
                s -= col_sum[x - ww];
                sq -= col_sq[x - ww];
            end
            win_sum = s & 32'h3FFFF;
            win_sq = sq & 32'h3FFFFFF;
        end
        if (x + 1 >= ww && y + 1 >= wh)
        begin
            tx = x + 1 - ww;
            ty = y + 1 - wh;
            if (tx + ww < w && ty + wh < h)
            begin
                n = ww * wh;
                a = n * win_sq;
                b = longint'(win_sum) * win_sum;
                q = 0;
                if (a > b)
                    q = ((a - b) << 16) / (n * (n - 1));
                r = int_sqrt(q);
                if (r > 64'hFFFF)
                    r = 64'hFFFF;
                e.win_x = tx[9:0];
                e.win_y = ty[9:0];
                e.std_dev = r[15:0];
                stat_q.push_back(e);
            end
        end
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        cur_x = x & 32'h3FF;
        cur_y = y & 32'h3FF;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stat_t got, want;
        if (!rst_n)
        begin
            img_w_reg = 11'd640;
            img_h_reg = 11'd480;
            win_w_reg = 6'd24;
            win_h_reg = 6'd24;
            win_sum = 0;
            win_sq = 0;
            cur_x = 0;
            cur_y = 0;
            errors = 0;
            stat_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[35:0];
                if (stat_q.size() == 0)
                begin
                    $error("unexpected word %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = stat_q.pop_front();
                    if (got.win_x !== want.win_x)
                    begin
                        $error("win_x exp %0d got %0d", want.win_x, got.win_x);
                        errors++;
                    end
                    if (got.win_y !== want.win_y)
                    begin
                        $error("win_y exp %0d got %0d", want.win_y, got.win_y);
                        errors++;
                    end
                    if (got.std_dev !== want.std_dev)
                    begin
                        $error("std_dev exp %0d got %0d", want.std_dev, got.std_dev);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_pixel(32'(s_tdata), s_tuser);
            if (cfg_we)
                case (cfg_index)
                    REG_IMAGE_WIDTH:   img_w_reg = cfg_data;
                    REG_IMAGE_HEIGHT:  img_h_reg = cfg_data;
                    REG_WINDOW_WIDTH:  win_w_reg = cfg_data[5:0];
                    REG_WINDOW_HEIGHT: win_h_reg = cfg_data[5:0];
                    default: ;
                endcase
        end
        pending = stat_q.size();
    end
endmodule

// ===== dv/tb.sv =====
// Testbench top: clock, reset, pixel stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
module tb import wsdm_pkg::*;;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid, s_tready, s_tuser;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    int          errors, pending, words_out;
    int          pix_mode;

    window_std_dev_map dut (.*);

    window_std_dev_map_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        int r;
        r = int'($urandom_range(99));
        if (r < 65)
            return 0;
        if (r < 95)
            return int'($urandom_range(3, 1));
        return int'($urandom_range(60, 15));
    endfunction

    function automatic logic [7:0] next_pixel();
        case (pix_mode)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            2: return 8'd128;
            default: return 8'($urandom_range(20, 10));
        endcase
    endfunction

    task automatic set_geometry(input int w, input int h, input int ww, input int wh);
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= 11'(w);
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= 11'(h);
        @(posedge clk);
        cfg_index <= REG_WINDOW_WIDTH;
        cfg_data <= 11'(ww);
        @(posedge clk);
        cfg_index <= REG_WINDOW_HEIGHT;
        cfg_data <= 11'(wh);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] p, input bit fs);
        int g;
        s_tvalid <= 1'b1;
        s_tdata <= p;
        s_tuser <= fs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // first pixel marks the frame; rare mid-image frame marks restart position
    task automatic send_run(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(next_pixel(), i == 0 || $urandom_range(199) == 0);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // sink: random stalls, plus one long hold-off to fill the block
    initial
    begin
        int g;
        bit held;
        m_tready <= 1'b0;
        held = 0;
        words_out = 0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid)
                words_out++;
            if (!held && words_out >= 20)
            begin
                held = 1;
                m_tready <= 1'b0;
                repeat (1500) @(posedge clk);
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int w, h, ww, wh;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= '0;
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, extreme pixels
        pix_mode = 1;
        send_run(20);
        drain();
        // small image, random extremes then flat
        set_geometry(8, 6, 2, 2);
        send_run(48);
        pix_mode = 2;
        send_run(48);
        drain();
        // out-of-range low values: window equals image, no results
        pix_mode = 0;
        set_geometry(0, 1, 0, 1);
        send_run(10);
        drain();
        // out-of-range high image size (clamped), no full row
        set_geometry(2047, 2047, 2, 2);
        send_run(60);
        drain();
        // widest window (clamped)
        pix_mode = 1;
        set_geometry(34, 3, 63, 2);
        send_run(34 * 3);
        drain();
        // tallest window (clamped)
        set_geometry(3, 34, 2, 63);
        send_run(3 * 34);
        drain();

        for (int k = 0; k < 3; k++)
        begin
            w = int'($urandom_range(12, 4));
            h = int'($urandom_range(8, 3));
            ww = int'($urandom_range(w > 8 ? 8 : w, 2));
            wh = int'($urandom_range(h > 6 ? 6 : h, 2));
            pix_mode = int'($urandom_range(3));
            if (pix_mode == 2)
                pix_mode = 0;
            set_geometry(w, h, ww, wh);
            send_run(w * h + int'($urandom_range(5)));
            drain();
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/wsdm_pkg.sv
hdl/wsdm_ram.sv
hdl/wsdm_front.sv
hdl/wsdm_queue.sv
hdl/wsdm_back.sv
hdl/window_std_dev_map.sv
dv/window_std_dev_map_checker.sv
dv/tb.sv
